// ===== sv/bounded_set_store_macros.svh =====
// ----------------------------------------------------------------------------
// Bounded set store assertion macros
// Concurrent assertion wrappers used by the set store datapath.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_SET_STORE_MACROS_SVH
`define BOUNDED_SET_STORE_MACROS_SVH

`ifndef ASSERT_OFF

`define BSS_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define BSS_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define BSS_ASSERT(label, clk, rst_n, prop, msg)

`define BSS_ASSERT_NEVER(label, clk, rst_n, cond, msg)

`endif

`endif

// ===== sv/bss_pkg.sv =====
// ----------------------------------------------------------------------------
// Bounded set store package
// Transaction types, action codes, controller states and defaults.
// ----------------------------------------------------------------------------
`default_nettype none

package bss_pkg;

  localparam int DEF_CAPACITY      = 16;
  localparam int DEF_ELEMENT_WIDTH = 32;
  localparam int ELEMENT_PORT_W    = 32;
  localparam int COUNT_W           = 5;

  typedef enum logic [1:0] {
    ACT_QUERY  = 2'd0,
    ACT_INSERT = 2'd1,
    ACT_REMOVE = 2'd2,
    ACT_CLEAR  = 2'd3
  } action_t;

  typedef struct packed {
    logic [1:0]                action;
    logic [ELEMENT_PORT_W-1:0] element;
  } in_t;

  typedef struct packed {
    logic               was_present;
    logic               changed;
    logic [COUNT_W-1:0] count;
    logic               is_full;
    logic               is_empty;
  } out_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_t;

  typedef struct packed {
    logic capture;
    logic execute;
  } cmd_t;

endpackage

`default_nettype wire

// ===== sv/bss_ctrl.sv =====
// ----------------------------------------------------------------------------
// Bounded set store controller
// Sequences capture and execute, owns the handshakes and result valid.
// ----------------------------------------------------------------------------
`default_nettype none

module bss_ctrl (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  output logic             out_valid,
  input  wire logic        out_stall,
  output bss_pkg::cmd_t    cmd
);

  bss_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bss_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    in_stall    = 1'b1;
    cmd.capture = 1'b0;
    cmd.execute = 1'b0;
    case (state_r)
      bss_pkg::ST_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = in_valid;
        if (in_valid) begin
          state_nxt = bss_pkg::ST_EXEC;
        end
      end
      bss_pkg::ST_EXEC: begin
        // result register must be free or draining this cycle
        if (!out_valid_r || !out_stall) begin
          cmd.execute = 1'b1;
          state_nxt   = bss_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = bss_pkg::ST_IDLE;
      end
    endcase
    out_valid_nxt = cmd.execute | (out_valid_r & out_stall);
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

// ===== sv/bss_dp.sv =====
// ----------------------------------------------------------------------------
// Bounded set store datapath
// Entry row with per-entry compare, shift-down remove, count and result.
// ----------------------------------------------------------------------------
`default_nettype none

`include "bounded_set_store_macros.svh"

module bss_dp #(
  parameter int CAPACITY      = bss_pkg::DEF_CAPACITY,
  parameter int ELEMENT_WIDTH = bss_pkg::DEF_ELEMENT_WIDTH
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire bss_pkg::cmd_t cmd,
  input  wire bss_pkg::in_t  in_data,
  output bss_pkg::out_t      out_data
);

  localparam int SW    = (ELEMENT_WIDTH < bss_pkg::ELEMENT_PORT_W) ?
                         ELEMENT_WIDTH : bss_pkg::ELEMENT_PORT_W;
  localparam int CNT_W = $clog2(CAPACITY + 1);

  bss_pkg::action_t act_r;
  logic [SW-1:0]    val_r;
  logic [SW-1:0]    entries_r   [CAPACITY];
  logic [SW-1:0]    entries_nxt [CAPACITY];
  logic [SW-1:0]    shift_src   [CAPACITY];
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  bss_pkg::out_t    out_r, out_nxt;

  logic [CAPACITY-1:0] match;
  logic [CAPACITY-1:0] at_or_above;
  logic                present;
  logic                full;
  logic                do_ins;
  logic                do_rem;
  logic                do_clr;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    assign match[g]       = (CNT_W'(g) < cnt_r) && (entries_r[g] == val_r);
    assign at_or_above[g] = |match[g:0];
    if (g < CAPACITY - 1) begin : g_shift
      assign shift_src[g] = entries_r[g+1];
    end else begin : g_last
      assign shift_src[g] = entries_r[g];
    end
  end

  assign present = |match;
  assign full    = (cnt_r == CNT_W'(CAPACITY));
  assign do_ins  = (act_r == bss_pkg::ACT_INSERT) && !present && !full;
  assign do_rem  = (act_r == bss_pkg::ACT_REMOVE) && present;
  assign do_clr  = (act_r == bss_pkg::ACT_CLEAR);

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      entries_nxt[i] = entries_r[i];
      if (do_rem && at_or_above[i]) begin
        entries_nxt[i] = shift_src[i];
      end else if (do_ins && (cnt_r == CNT_W'(i))) begin
        entries_nxt[i] = val_r;
      end
    end

    cnt_nxt = cnt_r;
    if (do_clr) begin
      cnt_nxt = '0;
    end else if (do_ins) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (do_rem) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end

    out_nxt.was_present = present;
    out_nxt.changed     = do_ins | do_rem | do_clr;
    out_nxt.count       = bss_pkg::COUNT_W'(cnt_nxt);
    out_nxt.is_full     = (cnt_nxt == CNT_W'(CAPACITY));
    out_nxt.is_empty    = (cnt_nxt == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.execute) begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act_r <= bss_pkg::action_t'(in_data.action);
      val_r <= in_data.element[SW-1:0];
    end
    if (cmd.execute) begin
      entries_r <= entries_nxt;
      out_r     <= out_nxt;
    end
  end

  assign out_data = out_r;

  `BSS_ASSERT_NEVER(a_cnt_bound, clk, rst_n, cnt_r > CNT_W'(CAPACITY), "count above capacity")
  `BSS_ASSERT(a_cnt_hold, clk, rst_n, !cmd.execute |=> $stable(cnt_r), "count moved while idle")
  `BSS_ASSERT(a_clear, clk, rst_n, (cmd.execute && act_r == bss_pkg::ACT_CLEAR) |=> (cnt_r == '0), "clear left entries")
  `BSS_ASSERT_NEVER(a_cmd_excl, clk, rst_n, cmd.capture && cmd.execute, "capture during execute")

endmodule

`default_nettype wire

// ===== sv/bounded_set_store.sv =====
// ----------------------------------------------------------------------------
// Bounded set store
// Set of up to CAPACITY distinct elements: query, insert, remove, clear.
// ----------------------------------------------------------------------------
//  channel  | handshake            | payload
//  ---------+----------------------+--------------------------------------
//  in       | in_valid / in_stall   | bss_pkg::in_t  (action, element)
//  out      | out_valid / out_stall | bss_pkg::out_t (was_present, changed,
//           |                       |   count, is_full, is_empty)
//
//  Each transaction is captured, then executed; in execute every entry
//  compares in parallel and a remove shifts the row down by one.
//  A new transaction is taken while the previous result waits downstream;
//  execute holds while the result register is full and stalled.
//  Synchronous active-low reset empties the set; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_set_store #(
  parameter int CAPACITY      = bss_pkg::DEF_CAPACITY,
  parameter int ELEMENT_WIDTH = bss_pkg::DEF_ELEMENT_WIDTH
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_stall,
  input  wire bss_pkg::in_t in_data,
  output logic              out_valid,
  input  wire logic         out_stall,
  output bss_pkg::out_t     out_data
);

  bss_pkg::cmd_t cmd;

  bss_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  bss_dp #(
    .CAPACITY      (CAPACITY),
    .ELEMENT_WIDTH (ELEMENT_WIDTH)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_data  (in_data),
    .out_data (out_data)
  );

endmodule

`default_nettype wire

// ===== test/tb_bounded_set_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded set store testbench
// Drives query, insert, remove and clear transactions with random gaps and
// back-pressure. A shadow copy of the set predicts each result, and every
// result leaving the block is compared field by field, in order.
// ----------------------------------------------------------------------------
module tb_bounded_set_store;

  localparam int SET_CAP = bss_pkg::DEF_CAPACITY;
  localparam int IDLE_PCT = 29;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  bss_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  bss_pkg::out_t out_data;

  logic [bss_pkg::ELEMENT_PORT_W-1:0] shadow_set[$];
  bss_pkg::out_t expected_results[$];
  int mismatches = 0;
  bit idle_en = 1'b1;

  int hold_req = 0;
  int hold_len = 0;
  int hold_seen = 0;
  int hold_left = 0;

  logic [bss_pkg::ELEMENT_PORT_W-1:0] elem_pool[24];

  bounded_set_store dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #5ms;
    $display("TB_ERROR");
    $finish;
  end

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    if (mismatches < 30)
      $display("%0t: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
    mismatches++;
  endtask

  // Applies one transaction to the shadow set and returns the expected result
  function automatic bss_pkg::out_t apply_to_shadow(bss_pkg::action_t act,
                                                    logic [bss_pkg::ELEMENT_PORT_W-1:0] elem);
    int pos;
    bss_pkg::out_t res;
    pos = -1;
    foreach (shadow_set[i])
      if (pos < 0 && shadow_set[i] == elem) pos = i;
    res = '0;
    res.was_present = (pos >= 0);
    case (act)
      bss_pkg::ACT_INSERT: begin
        if (pos < 0 && shadow_set.size() < SET_CAP) begin
          shadow_set.push_back(elem);
          res.changed = 1'b1;
        end
      end
      bss_pkg::ACT_REMOVE: begin
        if (pos >= 0) begin
          shadow_set.delete(pos);
          res.changed = 1'b1;
        end
      end
      bss_pkg::ACT_CLEAR: begin
        shadow_set.delete();
        res.changed = 1'b1;
      end
      default: ;
    endcase
    res.count = bss_pkg::COUNT_W'(shadow_set.size());
    res.is_full = (shadow_set.size() == SET_CAP);
    res.is_empty = (shadow_set.size() == 0);
    return res;
  endfunction

  // Returns at the edge that accepts the transaction, valid still high
  task automatic send_txn(input bss_pkg::action_t act,
                          input logic [bss_pkg::ELEMENT_PORT_W-1:0] elem);
    while (idle_en && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{act, elem};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_results.push_back(apply_to_shadow(act, elem));
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= hold_len;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= idle_en && ($urandom_range(99) < IDLE_PCT);
    end
  end

  always @(posedge clk) begin : result_check
    bss_pkg::out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        flag_mismatch("unexpected result", 32'(out_data), 32'd0);
      end else begin
        want = expected_results.pop_front();
        if (out_data.was_present !== want.was_present)
          flag_mismatch("was_present", 32'(out_data.was_present), 32'(want.was_present));
        if (out_data.changed !== want.changed)
          flag_mismatch("changed", 32'(out_data.changed), 32'(want.changed));
        if (out_data.count !== want.count)
          flag_mismatch("count", 32'(out_data.count), 32'(want.count));
        if (out_data.is_full !== want.is_full)
          flag_mismatch("is_full", 32'(out_data.is_full), 32'(want.is_full));
        if (out_data.is_empty !== want.is_empty)
          flag_mismatch("is_empty", 32'(out_data.is_empty), 32'(want.is_empty));
      end
    end
  end

  task automatic send_random(input int n);
    int r;
    bss_pkg::action_t act;
    logic [bss_pkg::ELEMENT_PORT_W-1:0] elem;
    repeat (n) begin
      r = $urandom_range(99);
      act = (r < 30) ? bss_pkg::ACT_QUERY :
            (r < 70) ? bss_pkg::ACT_INSERT :
            (r < 95) ? bss_pkg::ACT_REMOVE : bss_pkg::ACT_CLEAR;
      elem = ($urandom_range(9) == 0) ? $urandom() : elem_pool[$urandom_range(23)];
      send_txn(act, elem);
    end
  endtask

  task automatic refill_pool();
    foreach (elem_pool[i]) elem_pool[i] = $urandom();
    elem_pool[0] = '0;
    elem_pool[1] = '1;
  endtask

  // Edge values, absent remove, duplicate insert, remove with shift, clear
  task automatic test_edge_values();
    send_txn(bss_pkg::ACT_QUERY, '0);
    send_txn(bss_pkg::ACT_REMOVE, '1);
    send_txn(bss_pkg::ACT_CLEAR, '0);
    send_txn(bss_pkg::ACT_INSERT, '0);
    send_txn(bss_pkg::ACT_INSERT, '1);
    send_txn(bss_pkg::ACT_INSERT, 32'h8000_0001);
    send_txn(bss_pkg::ACT_INSERT, '0);
    send_txn(bss_pkg::ACT_REMOVE, '0);
    send_txn(bss_pkg::ACT_QUERY, 32'h8000_0001);
    send_txn(bss_pkg::ACT_CLEAR, '1);
    wait_drain();
  endtask

  // Fill to capacity, reject overflow and duplicates, remove inside, clear
  task automatic test_full_set();
    for (int i = 0; i < SET_CAP; i++) send_txn(bss_pkg::ACT_INSERT, 32'h5A5A_0000 + i);
    send_txn(bss_pkg::ACT_INSERT, 32'hA5A5_FFFF);
    send_txn(bss_pkg::ACT_INSERT, 32'h5A5A_0003);
    send_txn(bss_pkg::ACT_REMOVE, 32'h5A5A_0007);
    send_txn(bss_pkg::ACT_CLEAR, 32'h5A5A_0000);
    wait_drain();
  endtask

  task automatic test_random_mix();
    for (int p = 0; p < 5; p++) begin
      refill_pool();
      send_random(140);
      wait_drain();
    end
  endtask

  task automatic test_no_idle();
    idle_en = 1'b0;
    refill_pool();
    send_random(100);
    wait_drain();
    idle_en = 1'b1;
  endtask

  // Receiver holds off while the sender keeps offering, then sender pauses
  task automatic test_backpressure();
    hold_len = 300;
    hold_req++;
    refill_pool();
    send_random(40);
    wait_drain();
    send_random(60);
    wait_drain();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_edge_values();
    test_full_set();
    test_random_mix();
    test_no_idle();
    test_backpressure();
    repeat (10) @(posedge clk);
    if (mismatches == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
